// ===== hw/rtl/vhd_pkg.sv =====
// Vector heading package: shared types, angle constants and the tangent table.
// No dependencies; used by every module of the vector heading block.
`default_nettype none
package vhd_pkg;

   localparam int NUM_CELLS = 44;
   localparam int SPLIT     = 30;

   typedef logic [8:0] deg_type;
   typedef logic [5:0] cnt_type;

   typedef enum logic [1:0] {
      QUAD_0   = 2'd0,
      QUAD_90  = 2'd1,
      QUAD_180 = 2'd2,
      QUAD_270 = 2'd3
   } quad_type;

   typedef struct packed {
      logic     fixed;
      deg_type  fixed_deg;
      quad_type quad;
      logic     odd;
   } side_type;

   localparam deg_type DEG_0   = 9'd0;
   localparam deg_type DEG_45  = 9'd45;
   localparam deg_type DEG_90  = 9'd90;
   localparam deg_type DEG_180 = 9'd180;
   localparam deg_type DEG_270 = 9'd270;
   localparam deg_type DEG_360 = 9'd360;

   // tan(k deg) scaled by 1e18, k = 1..44
   localparam logic [59:0] TAN_SCALE = 60'd1000000000000000000;

   localparam logic [59:0] TAN_DEG [NUM_CELLS] = '{
      60'd17455064928217585,  60'd34920769491747730,  60'd52407779283041210,
      60'd69926811943510410,  60'd87488663525924010,  60'd105104235265676460,
      60'd122784560902904600, 60'd140540834702391430, 60'd158384440324536270,
      60'd176326980708464980, 60'd194380309137718480, 60'd212556561670022130,
      60'd230868191125563100, 60'd249328002843180680, 60'd267949192431122706,
      60'd286745385758807900, 60'd305730681458660330, 60'd324919696232906300,
      60'd344327613289665200, 60'd363970234266202340, 60'd383864035035415800,
      60'd404026225835156800, 60'd424474816209604700, 60'd445228685308536100,
      60'd466307658154998600, 60'd487732588565861440, 60'd509525449494428800,
      60'd531709431661478800, 60'd554309051452769100, 60'd577350269189625765,
      60'd600860619027560400, 60'd624869351909327500, 60'd649407593197510600,
      60'd674508516842426700, 60'd700207538209709700, 60'd726542528005360900,
      60'd753554050102794200, 60'd781285626506717400, 60'd809784033195007200,
      60'd839099631177279900, 60'd869286737816226700, 60'd900404044297839900,
      60'd932515086137661500, 60'd965688774807073900
   };

endpackage
`default_nettype wire

// ===== hw/rtl/vhd_req_if.sv =====
// Input channel of the vector heading block: valid/ready plus the vector.
// No dependencies.
`default_nettype none
interface vhd_req_if #(parameter int COORD_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] vec_x;
   logic signed [COORD_WIDTH-1:0] vec_y;

   modport source (output valid, output vec_x, output vec_y, input ready);
   modport sink   (input valid, input vec_x, input vec_y, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/vhd_rsp_if.sv =====
// Result channel of the vector heading block: valid/ready plus the heading.
// No dependencies.
`default_nettype none
interface vhd_rsp_if;
   logic       valid;
   logic       ready;
   logic [8:0] heading_deg;

   modport source (output valid, output heading_deg, input ready);
   modport sink   (input valid, input heading_deg, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/vhd_front.sv =====
// Front end: octant, axis cases and the scaled numerator/denominator, 3 stages.
// Depends on vhd_pkg and vhd_req_if.
`default_nettype none
module vhd_front #(
   parameter int COORD_WIDTH = 16
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             en,
   vhd_req_if.sink                         req_if,
   output logic                            out_valid,
   output vhd_pkg::side_type               out_side,
   output logic [COORD_WIDTH+59:0]         out_nums,
   output logic [COORD_WIDTH:0]            out_den
);
   import vhd_pkg::*;

   localparam int W  = COORD_WIDTH;
   localparam int NW = COORD_WIDTH + 60;
   localparam logic [SPLIT-1:0] S_LO = TAN_SCALE[SPLIT-1:0];
   localparam logic [SPLIT-1:0] S_HI = TAN_SCALE[2*SPLIT-1:SPLIT];

   logic [W-1:0]   xr, yr, xm, ym, p, q, num_in;
   logic           xn, yn;
   logic [W:0]     den_in;
   side_type       side_in;

   logic           v0_ff, v1_ff, v2_ff;
   side_type       side0_ff, side1_ff, side2_ff;
   logic [W-1:0]   num0_ff;
   logic [W:0]     den0_ff, den1_ff, den2_ff;
   logic [W+SPLIT-1:0] pl_in, ph_in, pl_ff, ph_ff;
   logic [NW-1:0]  nums_in, nums_ff;

   assign req_if.ready = en;

   always_comb begin
      xr = req_if.vec_x;
      yr = req_if.vec_y;
      xn = xr[W-1];
      yn = yr[W-1];
      xm = xn ? W'(~xr + 1'b1) : xr;
      ym = yn ? W'(~yr + 1'b1) : yr;
      p  = (xm < ym) ? xm : ym;
      q  = (xm < ym) ? ym : xm;
      num_in = q - p;
      den_in = {1'b0, q} + {1'b0, p};

      side_in.fixed     = 1'b0;
      side_in.fixed_deg = DEG_0;
      if (xm == '0 && ym == '0) begin
         side_in.fixed = 1'b1;
      end else if (xm == '0) begin
         side_in.fixed     = 1'b1;
         side_in.fixed_deg = yn ? DEG_90 : DEG_270;
      end else if (ym == '0) begin
         side_in.fixed     = 1'b1;
         side_in.fixed_deg = xn ? DEG_180 : DEG_0;
      end

      if (!xn && yn) begin
         side_in.quad = QUAD_0;
         side_in.odd  = xm > ym;
      end else if (xn && yn) begin
         side_in.quad = QUAD_90;
         side_in.odd  = ym > xm;
      end else if (xn && !yn) begin
         side_in.quad = QUAD_180;
         side_in.odd  = xm > ym;
      end else begin
         side_in.quad = QUAD_270;
         side_in.odd  = ym > xm;
      end
   end

   assign pl_in   = (W+SPLIT)'(num0_ff) * (W+SPLIT)'(S_LO);
   assign ph_in   = (W+SPLIT)'(num0_ff) * (W+SPLIT)'(S_HI);
   assign nums_in = NW'(pl_ff) + (NW'(ph_ff) << SPLIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_if.valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side0_ff <= side_in;
         num0_ff  <= num_in;
         den0_ff  <= den_in;
         side1_ff <= side0_ff;
         den1_ff  <= den0_ff;
         pl_ff    <= pl_in;
         ph_ff    <= ph_in;
         side2_ff <= side1_ff;
         den2_ff  <= den1_ff;
         nums_ff  <= nums_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_side  = side2_ff;
   assign out_nums  = nums_ff;
   assign out_den   = den2_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/vhd_cell.sv =====
// One degree cell: tests tan(k deg)*den <= num*scale and counts passes, 2 stages.
// Depends on vhd_pkg.
`default_nettype none
module vhd_cell #(
   parameter int COORD_WIDTH = 16,
   parameter int CELL_IDX    = 0
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        en,
   input  wire                        in_valid,
   input  wire vhd_pkg::side_type     in_side,
   input  wire [COORD_WIDTH+59:0]     in_nums,
   input  wire [COORD_WIDTH:0]        in_den,
   input  wire vhd_pkg::cnt_type      in_cnt,
   output logic                       out_valid,
   output vhd_pkg::side_type          out_side,
   output logic [COORD_WIDTH+59:0]    out_nums,
   output logic [COORD_WIDTH:0]       out_den,
   output vhd_pkg::cnt_type           out_cnt
);
   import vhd_pkg::*;

   localparam int DW = COORD_WIDTH + 1;
   localparam int NW = COORD_WIDTH + 60;
   localparam int PW = COORD_WIDTH + 61;
   localparam logic [59:0]      TAN  = TAN_DEG[CELL_IDX];
   localparam logic [SPLIT-1:0] T_LO = TAN[SPLIT-1:0];
   localparam logic [SPLIT-1:0] T_HI = TAN[2*SPLIT-1:SPLIT];

   logic                 va_ff, vb_ff;
   side_type             sa_ff, sb_ff;
   logic [NW-1:0]        na_ff, nb_ff;
   logic [DW-1:0]        da_ff, db_ff;
   cnt_type              ca_ff, cb_ff, cb_in;
   logic [DW+SPLIT-1:0]  tl_in, th_in, tl_ff, th_ff;
   logic [PW-1:0]        prod;
   logic                 pass;

   assign tl_in = (DW+SPLIT)'(in_den) * (DW+SPLIT)'(T_LO);
   assign th_in = (DW+SPLIT)'(in_den) * (DW+SPLIT)'(T_HI);
   assign prod  = PW'(tl_ff) + (PW'(th_ff) << SPLIT);
   assign pass  = prod <= PW'(na_ff);
   assign cb_in = ca_ff + cnt_type'(pass);

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sa_ff <= in_side;
         na_ff <= in_nums;
         da_ff <= in_den;
         ca_ff <= in_cnt;
         tl_ff <= tl_in;
         th_ff <= th_in;
         sb_ff <= sa_ff;
         nb_ff <= na_ff;
         db_ff <= da_ff;
         cb_ff <= cb_in;
      end
   end

   assign out_valid = vb_ff;
   assign out_side  = sb_ff;
   assign out_nums  = nb_ff;
   assign out_den   = db_ff;
   assign out_cnt   = cb_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/vhd_back.sv =====
// Back end: heading from octant and degree count, two-entry result queue.
// Depends on vhd_pkg and vhd_rsp_if.
`default_nettype none
module vhd_back (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     in_valid,
   input  wire vhd_pkg::side_type  in_side,
   input  wire vhd_pkg::cnt_type   in_cnt,
   output logic                    en,
   vhd_rsp_if.source               rsp_if
);
   import vhd_pkg::*;

   deg_type    base, heading;
   deg_type    q_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   always_comb begin
      case (in_side.quad)
         QUAD_0:   base = DEG_0;
         QUAD_90:  base = DEG_90;
         QUAD_180: base = DEG_180;
         QUAD_270: base = DEG_270;
         default:  base = DEG_0;
      endcase
      if (in_side.fixed)
         heading = in_side.fixed_deg;
      else if (in_side.odd)
         heading = base + DEG_45 - deg_type'(in_cnt);
      else
         heading = base + DEG_45 + deg_type'(in_cnt);
   end

   assign en       = count_ff != 2'd2;
   assign push     = en && in_valid;
   assign pop      = rsp_if.valid && rsp_if.ready;
   assign count_in = count_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop)  rd_ff <= ~rd_ff;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= heading;
   end

   assign rsp_if.valid       = count_ff != 2'd0;
   assign rsp_if.heading_deg = q_ff[rd_ff];

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result queue count out of range");

   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> rsp_if.heading_deg < DEG_360)
      else $error("heading out of range");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> count_ff == $past(count_ff) - 2'd1)
      else $error("result queue count did not drop on transfer");

endmodule
`default_nettype wire

// ===== hw/rtl/vector_heading_degrees.sv =====
// Vector heading in whole degrees: top level, a row of 44 degree cells.
// Depends on vhd_pkg, vhd_req_if, vhd_rsp_if, vhd_front, vhd_cell, vhd_back.
//
// Takes one vector per clock while not halted and returns one heading per vector, in order.
// A result passes through three front-end stages, two stages in each of the
// 44 degree cells and the write into the two-entry result queue. The whole
// pipeline moves together and halts only while that queue holds two results;
// req_if.ready is low exactly then.
`default_nettype none
module vector_heading_degrees #(
   parameter int COORD_WIDTH = 16
) (
   input  wire        clock,
   input  wire        reset,
   vhd_req_if.sink    req_if,
   vhd_rsp_if.source  rsp_if
);
   import vhd_pkg::*;

   logic                     en;
   logic                     valid_c [NUM_CELLS+1];
   side_type                 side_c  [NUM_CELLS+1];
   logic [COORD_WIDTH+59:0]  nums_c  [NUM_CELLS+1];
   logic [COORD_WIDTH:0]     den_c   [NUM_CELLS+1];
   cnt_type                  cnt_c   [NUM_CELLS+1];

   vhd_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .req_if    (req_if),
      .out_valid (valid_c[0]),
      .out_side  (side_c[0]),
      .out_nums  (nums_c[0]),
      .out_den   (den_c[0])
   );

   assign cnt_c[0] = '0;

   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      vhd_cell #(.COORD_WIDTH(COORD_WIDTH), .CELL_IDX(k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (valid_c[k]),
         .in_side   (side_c[k]),
         .in_nums   (nums_c[k]),
         .in_den    (den_c[k]),
         .in_cnt    (cnt_c[k]),
         .out_valid (valid_c[k+1]),
         .out_side  (side_c[k+1]),
         .out_nums  (nums_c[k+1]),
         .out_den   (den_c[k+1]),
         .out_cnt   (cnt_c[k+1])
      );
   end

   vhd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (valid_c[NUM_CELLS]),
      .in_side  (side_c[NUM_CELLS]),
      .in_cnt   (cnt_c[NUM_CELLS]),
      .en       (en),
      .rsp_if   (rsp_if)
   );

endmodule
`default_nettype wire

// ===== sim/tb_vector_heading_degrees.sv =====
// Testbench for vector_heading_degrees: directed and random vectors with random stalls.
// Depends on vhd_pkg, vhd_req_if, vhd_rsp_if and the vector_heading_degrees RTL;
// each returned heading is checked in order against an in-bench angle predictor.
`default_nettype none
module tb_vector_heading_degrees;
   import vhd_pkg::*;

   localparam int COORD_W       = 16;
   localparam int IDLE_PCT      = 31;
   localparam int RANDOM_ITEMS  = 2000;
   localparam int DRAIN_CYCLES  = 120;
   localparam int STUCK_LIMIT   = 2000;

   localparam logic [59:0] TAN_ONE = 60'd1000000000000000000;
   localparam logic [59:0] TAN_E18 [44] = '{
      60'd17455064928217585,  60'd34920769491747730,  60'd52407779283041210,
      60'd69926811943510410,  60'd87488663525924010,  60'd105104235265676460,
      60'd122784560902904600, 60'd140540834702391430, 60'd158384440324536270,
      60'd176326980708464980, 60'd194380309137718480, 60'd212556561670022130,
      60'd230868191125563100, 60'd249328002843180680, 60'd267949192431122706,
      60'd286745385758807900, 60'd305730681458660330, 60'd324919696232906300,
      60'd344327613289665200, 60'd363970234266202340, 60'd383864035035415800,
      60'd404026225835156800, 60'd424474816209604700, 60'd445228685308536100,
      60'd466307658154998600, 60'd487732588565861440, 60'd509525449494428800,
      60'd531709431661478800, 60'd554309051452769100, 60'd577350269189625765,
      60'd600860619027560400, 60'd624869351909327500, 60'd649407593197510600,
      60'd674508516842426700, 60'd700207538209709700, 60'd726542528005360900,
      60'd753554050102794200, 60'd781285626506717400, 60'd809784033195007200,
      60'd839099631177279900, 60'd869286737816226700, 60'd900404044297839900,
      60'd932515086137661500, 60'd965688774807073900
   };

   typedef struct {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      deg_type                   heading;
   } heading_entry_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   no_idle = 1'b0;
   int   error_count = 0;
   heading_entry_type pending_headings[$];

   vhd_req_if #(.COORD_WIDTH(COORD_W)) req_if ();
   vhd_rsp_if rsp_if ();

   vector_heading_degrees #(.COORD_WIDTH(COORD_W)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #5 clock = ~clock;

   function automatic deg_type heading_of(input logic signed [COORD_W-1:0] x,
                                          input logic signed [COORD_W-1:0] y);
      int           xm, ym, p, q, a, k, heading;
      bit           odd, going;
      quad_type     quad;
      logic [127:0] num, prod;
      xm = (x < 0) ? -int'(x) : int'(x);
      ym = (y < 0) ? -int'(y) : int'(y);
      if (xm == 0 && ym == 0) return DEG_0;
      if (xm == 0) return (y < 0) ? DEG_90 : DEG_270;
      if (ym == 0) return (x < 0) ? DEG_180 : DEG_0;
      if (x > 0 && y < 0) begin
         quad = QUAD_0;
         odd  = xm > ym;
      end else if (x < 0 && y < 0) begin
         quad = QUAD_90;
         odd  = ym > xm;
      end else if (x < 0) begin
         quad = QUAD_180;
         odd  = xm > ym;
      end else begin
         quad = QUAD_270;
         odd  = ym > xm;
      end
      p = (xm < ym) ? xm : ym;
      q = (xm < ym) ? ym : xm;
      num = 128'(q - p) * 128'(TAN_ONE);
      a = 0;
      going = 1'b1;
      for (k = 0; k < 44; k++) begin
         prod = 128'(TAN_E18[k]) * 128'(q + p);
         if (going && prod <= num) a = k + 1;
         else going = 1'b0;
      end
      heading = 90 * int'(quad) + 45 + (odd ? -a : a);
      return deg_type'(heading);
   endfunction

   function automatic logic signed [COORD_W-1:0] to_coord(input int mag, input bit neg);
      int v;
      v = neg ? -mag : mag;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[COORD_W-1:0];
   endfunction

   function automatic logic signed [COORD_W-1:0] edge_coord();
      case ($urandom_range(0, 5))
         0: return -16'sd32768;
         1: return -16'sd32767;
         2: return -16'sd1;
         3: return 16'sd0;
         4: return 16'sd1;
         default: return 16'sd32767;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      $display("tb: mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Transfer one vector; returns at the edge where it was taken.
   task automatic send_vector(input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y);
      bit                took;
      heading_entry_type entry;
      while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.vec_x <= x;
      req_if.vec_y <= y;
      do begin
         @(negedge clock);
         took = (req_if.ready === 1'b1);
         @(posedge clock);
      end while (!took);
      entry.x = x;
      entry.y = y;
      entry.heading = heading_of(x, y);
      pending_headings.push_back(entry);
   endtask

   task automatic test_zero_and_axes();
      send_vector(16'sd0, 16'sd0);
      send_vector(16'sd1, 16'sd0);
      send_vector(16'sd32767, 16'sd0);
      send_vector(16'sd0, -16'sd1);
      send_vector(16'sd0, -16'sd32768);
      send_vector(-16'sd32768, 16'sd0);
      send_vector(-16'sd5, 16'sd0);
      send_vector(16'sd0, 16'sd32767);
      send_vector(16'sd0, 16'sd7);
   endtask

   task automatic test_diagonals();
      send_vector(16'sd1, -16'sd1);
      send_vector(-16'sd1, -16'sd1);
      send_vector(-16'sd1, 16'sd1);
      send_vector(16'sd1, 16'sd1);
      send_vector(-16'sd32768, -16'sd32768);
      send_vector(16'sd32767, 16'sd32767);
   endtask

   task automatic test_octant_edges();
      send_vector(-16'sd32768, 16'sd32767);
      send_vector(16'sd32767, -16'sd32768);
      send_vector(-16'sd32768, 16'sd1);
      send_vector(16'sd1, -16'sd32768);
      send_vector(-16'sd32768, -16'sd1);
      send_vector(-16'sd100, -16'sd30);
      send_vector(-16'sd30, -16'sd100);
      send_vector(16'sd1000, -16'sd17);
   endtask

   task automatic test_random_vectors(input int count);
      int                        i, mag;
      logic signed [COORD_W-1:0] x, y;
      for (i = 0; i < count; i++) begin
         no_idle = (i >= count * 3 / 10) && (i < count / 2);
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               x = COORD_W'($urandom);
               y = COORD_W'($urandom);
            end
            4, 5: begin
               x = COORD_W'($urandom_range(0, 40) - 20);
               y = COORD_W'($urandom_range(0, 40) - 20);
            end
            6, 7: begin
               mag = $urandom_range(0, 32768);
               x = to_coord(mag, 1'($urandom_range(0, 1)));
               y = to_coord(mag + int'($urandom_range(0, 8)) - 4,
                            1'($urandom_range(0, 1)));
            end
            8: begin
               x = COORD_W'($urandom);
               y = COORD_W'($urandom);
               if ($urandom_range(0, 1)) x = '0;
               else y = '0;
            end
            default: begin
               x = edge_coord();
               y = edge_coord();
            end
         endcase
         send_vector(x, y);
      end
      no_idle = 1'b0;
   endtask

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   always @(negedge clock) begin
      heading_entry_type exp_entry;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_headings.size() == 0) begin
            report_mismatch($sformatf("unexpected heading %0d", rsp_if.heading_deg));
         end else begin
            exp_entry = pending_headings.pop_front();
            if (rsp_if.heading_deg !== exp_entry.heading)
               report_mismatch($sformatf("vector (%0d,%0d): heading %0d, expected %0d",
                  exp_entry.x, exp_entry.y, rsp_if.heading_deg, exp_entry.heading));
         end
      end
   end

   initial begin : watchdog
      int stuck_cycles;
      stuck_cycles = 0;
      while (stuck_cycles < STUCK_LIMIT) begin
         @(negedge clock);
         if (reset || (req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
             (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
            stuck_cycles = 0;
         else
            stuck_cycles++;
      end
      $display("tb: timeout, no transfer in %0d cycles", STUCK_LIMIT);
      $display("tb: failure");
      $finish;
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.vec_x = '0;
      req_if.vec_y = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_zero_and_axes();
      test_diagonals();
      test_octant_edges();
      test_random_vectors(RANDOM_ITEMS);
      req_if.valid <= 1'b0;

      while (pending_headings.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== files.f =====
hw/rtl/vhd_pkg.sv
hw/rtl/vhd_req_if.sv
hw/rtl/vhd_rsp_if.sv
hw/rtl/vhd_front.sv
hw/rtl/vhd_cell.sv
hw/rtl/vhd_back.sv
hw/rtl/vector_heading_degrees.sv
sim/tb_vector_heading_degrees.sv
